[src/assert_macros.svh]
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, or any property, checked while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent now, consequent on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/llwv_pkg.sv]
// Package: payload types, register indexes and constants of the log-law wall velocity block.
`default_nettype none

package llwv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int ROOT_W    = (VAL_W + FRAC_BITS) / 2;
    localparam int RAD_W     = 2 * ROOT_W;

    localparam int DIV_Q_W   = VAL_W;
    localparam int DIV_NUM_W = 2 * VAL_W;
    localparam int DIV_LAT   = DIV_Q_W + 1;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_SLIP = 2'd1;

    typedef enum logic [2:0] {
        CFG_BC_MODE     = 3'd0,
        CFG_CMU_QUARTER = 3'd1,
        CFG_LOG_LAW_E   = 3'd2,
        CFG_VON_KARMAN  = 3'd3,
        CFG_LAM_LIMIT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] tke;
        logic [31:0] viscosity;
        logic [31:0] wall_distance;
    } t_in;

    typedef struct packed {
        logic [31:0] wall_speed;
        logic [31:0] yplus;
        logic [31:0] log_scale;
        logic        error;
    } t_out;

    typedef struct packed {
        logic [31:0] yplus;
        logic [31:0] log_scale;
        logic [31:0] u_tau;
        logic [63:0] lin_prod;
        logic        log_br;
        logic        p_big;
    } t_side;

endpackage

`default_nettype wire

[src/log_law_wall_velocity_top.sv]
// Top level of the log-law wall velocity pipeline with its configuration registers.
`default_nettype none
`include "assert_macros.svh"

// Log-law wall velocity. One boundary-cell transaction (tke, viscosity,
// wall_distance, unsigned Q16.16) enters per clock. Its result transaction
// (wall_speed, yplus, log_scale, error) is presented in order at the output
// register. The datapath is a single 135-stage pipeline:
// - a 25-stage digit-by-digit square root (24 digit steps);
// - three stages for the uTau multiply, saturate and the divider numerators;
// - two 33-stage dividers in parallel for yPlus and the log scale;
// - a 7-stage normalise (E*yPlus captured, then 6 shift steps);
// - a 30-stage squaring log2;
// - three stages of ln scaling;
// - a third 33-stage divider by kappa;
// - the output register.
// Sustained rate is one transaction per cycle; the whole pipeline holds only
// while the output register is full and the sink is not ready. Configuration
// registers are written through the plain write port and must only change
// while no transaction is in flight.

module log_law_wall_velocity_top import llwv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    // pipeline positions
    localparam int P_B2     = ROOT_W + 3;
    localparam int P_C0     = P_B2 + DIV_LAT + 1;
    localparam int NM_STEPS = 6;
    localparam int NM_W     = 64;
    localparam int LG_STEPS = 30;
    localparam int P_L3     = P_C0 + NM_STEPS + LG_STEPS + 3;
    localparam int P_DW_END = P_L3 + DIV_LAT;
    localparam int P_OUT    = P_DW_END + 1;
    localparam int SD_LEN   = P_DW_END - P_C0 + 1;
    localparam int SD_U_L3  = P_L3 - 1 - P_C0;
    localparam int LN_SHIFT = 30 - FRAC_BITS;
    localparam int LNF_W    = 36 - LN_SHIFT;
    localparam int PROD_W   = VAL_W + ROOT_W;

    // configuration registers
    logic [1:0]  r_bc_mode;
    logic [31:0] r_cmu_quarter;
    logic [31:0] r_log_law_e;
    logic [31:0] r_von_karman;
    logic [31:0] r_lam_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_mode     <= MODE_ZERO;
            r_cmu_quarter <= 32'd35895;
            r_log_law_e   <= 32'd642253;
            r_von_karman  <= 32'd26870;
            r_lam_limit   <= 32'd755630;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BC_MODE:     r_bc_mode     <= i_cfg_data[1:0];
                CFG_CMU_QUARTER: r_cmu_quarter <= i_cfg_data;
                CFG_LOG_LAW_E:   r_log_law_e   <= i_cfg_data;
                CFG_VON_KARMAN:  r_von_karman  <= i_cfg_data;
                CFG_LAM_LIMIT:   r_lam_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output is held
    logic             w_adv;
    logic [P_OUT:0]   r_vld;

    assign w_adv      = !r_vld[P_OUT] || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[P_OUT-1:0], i_in_valid};
        end
    end

    // ---------------- square root of tke << F ----------------
    logic [RAD_W-1:0]  r_sq_x    [ROOT_W+1];
    logic [ROOT_W+1:0] r_sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W+1];
    logic [31:0]       r_sq_nu   [ROOT_W+1];
    logic [31:0]       r_sq_ds   [ROOT_W+1];
    logic [ROOT_W+2:0] w_sq_t    [ROOT_W];
    logic [ROOT_W+2:0] w_sq_test [ROOT_W];
    logic              w_sq_ge   [ROOT_W];
    logic [ROOT_W+2:0] n_sq_rem  [ROOT_W];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            w_sq_t[k]    = {r_sq_rem[k][ROOT_W:0], r_sq_x[k][RAD_W-1 -: 2]};
            w_sq_test[k] = {1'b0, r_sq_root[k], 2'b01};
            w_sq_ge[k]   = w_sq_t[k] >= w_sq_test[k];
            n_sq_rem[k]  = w_sq_ge[k] ? (w_sq_t[k] - w_sq_test[k]) : w_sq_t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_x[0]    <= {i_in_data.tke, {FRAC_BITS{1'b0}}};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_nu[0]   <= i_in_data.viscosity;
            r_sq_ds[0]   <= i_in_data.wall_distance;
            for (int k = 0; k < ROOT_W; k++) begin
                r_sq_x[k+1]    <= {r_sq_x[k][RAD_W-3:0], 2'b00};
                r_sq_rem[k+1]  <= n_sq_rem[k][ROOT_W+1:0];
                r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], w_sq_ge[k]};
                r_sq_nu[k+1]   <= r_sq_nu[k];
                r_sq_ds[k+1]   <= r_sq_ds[k];
            end
        end
    end

    // ---------------- uTau and divider numerators ----------------
    logic [PROD_W-1:0] r_b0_prod;
    logic [31:0]       r_b0_nu, r_b0_ds;
    logic [31:0]       r_b1_u, r_b1_nu, r_b1_ds;
    logic [63:0]       r_b2_numy, r_b2_numl;
    logic [31:0]       r_b2_nu, r_b2_u;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0_prod <= PROD_W'(r_cmu_quarter) * PROD_W'(r_sq_root[ROOT_W]);
            r_b0_nu   <= r_sq_nu[ROOT_W];
            r_b0_ds   <= r_sq_ds[ROOT_W];
            r_b1_u    <= (|r_b0_prod[PROD_W-1:VAL_W+FRAC_BITS]) ? '1
                         : r_b0_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
            r_b1_nu   <= r_b0_nu;
            r_b1_ds   <= r_b0_ds;
            r_b2_numy <= 64'(r_b1_u) * 64'(r_b1_ds);
            r_b2_numl <= 64'(r_log_law_e) * 64'(r_b1_u);
            r_b2_nu   <= r_b1_nu;
            r_b2_u    <= r_b1_u;
        end
    end

    logic [31:0] w_yp, w_ls, w_dw_q;
    logic [31:0] r_u_dl [DIV_LAT];

    llwv_div u_div_yplus (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_b2_numy),
        .i_den (r_b2_nu),
        .o_quo (w_yp)
    );

    llwv_div u_div_lscale (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_b2_numl),
        .i_den (r_b2_nu),
        .o_quo (w_ls)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u_dl[0] <= r_b2_u;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_u_dl[k] <= r_u_dl[k-1];
            end
        end
    end

    // ---------------- E*yPlus, linear product, sideband ----------------
    logic [63:0] w_c0_p;
    t_side       w_c0_side;
    t_side       r_sd [SD_LEN];

    always_comb begin
        w_c0_p              = 64'(r_log_law_e) * 64'(w_yp);
        w_c0_side.yplus     = w_yp;
        w_c0_side.log_scale = w_ls;
        w_c0_side.u_tau     = r_u_dl[DIV_LAT-1];
        w_c0_side.lin_prod  = 64'(w_yp) * 64'(r_u_dl[DIV_LAT-1]);
        w_c0_side.log_br    = w_yp > r_lam_limit;
        w_c0_side.p_big     = |w_c0_p[63:2*FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= w_c0_side;
            for (int k = 1; k < SD_LEN; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // ---------------- normalise P, msb to bit 63 ----------------
    logic [NM_W-1:0]     r_nm_p  [NM_STEPS+1];
    logic [NM_STEPS-1:0] r_nm_lz [NM_STEPS+1];
    logic                w_nm_z  [NM_STEPS];
    logic [NM_STEPS-1:0] n_nm_lz [NM_STEPS];

    always_comb begin
        for (int j = 0; j < NM_STEPS; j++) begin
            w_nm_z[j]  = (r_nm_p[j] >> (NM_W - ((NM_W / 2) >> j))) == '0;
            n_nm_lz[j] = r_nm_lz[j];
            n_nm_lz[j][NM_STEPS-1-j] = w_nm_z[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_nm_p[0]  <= w_c0_p;
            r_nm_lz[0] <= '0;
            for (int j = 0; j < NM_STEPS; j++) begin
                r_nm_p[j+1]  <= w_nm_z[j] ? (r_nm_p[j] << ((NM_W / 2) >> j)) : r_nm_p[j];
                r_nm_lz[j+1] <= n_nm_lz[j];
            end
        end
    end

    // ---------------- log2 fraction by repeated squaring ----------------
    logic [30:0] r_lg_m    [LG_STEPS];
    logic [29:0] r_lg_frac [LG_STEPS];
    logic [4:0]  r_lg_int  [LG_STEPS];
    logic [30:0] w_lg_min  [LG_STEPS];
    logic [29:0] w_lg_fin  [LG_STEPS];
    logic [4:0]  w_lg_iin  [LG_STEPS];
    logic [61:0] w_lg_sq   [LG_STEPS];
    logic [31:0] w_lg_t    [LG_STEPS];

    always_comb begin
        for (int k = 0; k < LG_STEPS; k++) begin
            if (k == 0) begin
                // integer part msb - 2F, valid when P >= 2^(2F)
                w_lg_min[k] = r_nm_p[NM_STEPS][NM_W-1 -: 31];
                w_lg_fin[k] = '0;
                w_lg_iin[k] = ~r_nm_lz[NM_STEPS][4:0];
            end else begin
                w_lg_min[k] = r_lg_m[k-1];
                w_lg_fin[k] = r_lg_frac[k-1];
                w_lg_iin[k] = r_lg_int[k-1];
            end
            w_lg_sq[k] = 62'(w_lg_min[k]) * 62'(w_lg_min[k]);
            w_lg_t[k]  = w_lg_sq[k][61:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < LG_STEPS; k++) begin
                r_lg_m[k]    <= w_lg_t[k][31] ? w_lg_t[k][31:1] : w_lg_t[k][30:0];
                r_lg_frac[k] <= {w_lg_fin[k][28:0], w_lg_t[k][31]};
                r_lg_int[k]  <= w_lg_iin[k];
            end
        end
    end

    // ---------------- ln scaling, times uTau ----------------
    logic [34:0]      r_l1_a;
    logic [59:0]      r_l1_b;
    logic [35:0]      w_l2_sum;
    logic [LNF_W-1:0] r_l2_lnf;
    logic [63:0]      r_l3_num;

    assign w_l2_sum = 36'(r_l1_a) + 36'(r_l1_b[59:30]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l1_a   <= 35'(r_lg_int[LG_STEPS-1]) * 35'(LN2_Q30);
            r_l1_b   <= 60'(r_lg_frac[LG_STEPS-1]) * 60'(LN2_Q30);
            r_l2_lnf <= w_l2_sum[35:LN_SHIFT];
            r_l3_num <= 64'(r_l2_lnf) * 64'(r_sd[SD_U_L3].u_tau);
        end
    end

    llwv_div u_div_kappa (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_l3_num),
        .i_den (r_von_karman),
        .o_quo (w_dw_q)
    );

    // ---------------- result select and output register ----------------
    t_side       w_f_side;
    logic [31:0] w_f_lin;
    logic [31:0] w_f_ws;
    t_out        n_out;
    t_out        r_out;

    always_comb begin
        w_f_side = r_sd[SD_LEN-1];
        w_f_lin  = (|w_f_side.lin_prod[63:VAL_W+FRAC_BITS]) ? '1
                   : w_f_side.lin_prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
        if (w_f_side.log_br) begin
            w_f_ws = w_f_side.p_big ? w_dw_q : '0;
        end else begin
            w_f_ws = w_f_lin;
        end
        n_out = '0;
        case (r_bc_mode)
            MODE_ZERO: n_out = '0;
            MODE_SLIP: begin
                n_out.wall_speed = w_f_ws;
                n_out.yplus      = w_f_side.yplus;
                n_out.log_scale  = w_f_side.log_scale;
            end
            default: n_out.error = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[P_OUT];
    assign o_out_data  = r_out;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_adv, $stable(r_vld), "pipeline moved while held")
    `ASSERT_CLK(a_err_mode, i_clk, i_rst_n, (o_out_valid && o_out_data.error) |-> (r_bc_mode != MODE_ZERO && r_bc_mode != MODE_SLIP), "error flag in a supported mode")
    `ASSERT_CLK(a_zero_mode, i_clk, i_rst_n, (o_out_valid && r_bc_mode == MODE_ZERO) |-> (o_out_data == '0), "non-zero result in zero mode")

endmodule

`default_nettype wire

[src/llwv_div.sv]
// Pipelined 64 by 32 bit unsigned divider, one quotient bit per stage, saturating.
`default_nettype none

module llwv_div import llwv_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_Q_W-1:0]   i_den,
    output logic      [DIV_Q_W-1:0]   o_quo
);

    logic [DIV_Q_W-1:0] r_rem [DIV_Q_W+1];
    logic [DIV_Q_W-1:0] r_lo  [DIV_Q_W+1];
    logic [DIV_Q_W-1:0] r_q   [DIV_Q_W+1];
    logic [DIV_Q_W-1:0] r_den [DIV_Q_W+1];
    logic               r_ovf [DIV_Q_W+1];

    logic [DIV_Q_W:0]   w_t   [DIV_Q_W];
    logic               w_ge  [DIV_Q_W];
    logic [DIV_Q_W:0]   n_rem [DIV_Q_W];

    always_comb begin
        for (int k = 0; k < DIV_Q_W; k++) begin
            w_t[k]   = {r_rem[k], r_lo[k][DIV_Q_W-1]};
            w_ge[k]  = w_t[k] >= {1'b0, r_den[k]};
            n_rem[k] = w_ge[k] ? (w_t[k] - {1'b0, r_den[k]}) : w_t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient overflows 32 bits (or divisor is zero): saturate
            r_ovf[0] <= i_num[DIV_NUM_W-1:DIV_Q_W] >= i_den;
            r_rem[0] <= i_num[DIV_NUM_W-1:DIV_Q_W];
            r_lo[0]  <= i_num[DIV_Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            for (int k = 0; k < DIV_Q_W; k++) begin
                r_rem[k+1] <= n_rem[k][DIV_Q_W-1:0];
                r_lo[k+1]  <= {r_lo[k][DIV_Q_W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][DIV_Q_W-2:0], w_ge[k]};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_ovf[DIV_Q_W] ? '1 : r_q[DIV_Q_W];

endmodule

`default_nettype wire
